// ===== hdl/htrb_pkg.sv =====
// Package for the handheld timer register block: command codes, special
// register addresses and the decoded item type. No dependencies.
`default_nettype none
package htrb_pkg;

   typedef enum logic [2:0] {
      CMD_WRITE = 3'd0,
      CMD_READ  = 3'd1,
      CMD_SEC   = 3'd2,
      CMD_FAST  = 3'd3,
      CMD_CYCLE = 3'd4
   } cmd_type;

   localparam logic [7:0] ADDR_SEC_CTL  = 8'h08;
   localparam logic [7:0] ADDR_SEC_B0   = 8'h09;
   localparam logic [7:0] ADDR_SEC_B1   = 8'h0A;
   localparam logic [7:0] ADDR_SEC_B2   = 8'h0B;
   localparam logic [7:0] ADDR_GROUP    = 8'h19;
   localparam logic [7:0] ADDR_FAST_CTL = 8'h40;
   localparam logic [7:0] ADDR_FAST_CNT = 8'h41;
   localparam logic [7:0] ADDR_KEYS     = 8'h52;

   typedef logic [7:0] addr3_type [3];
   localparam addr3_type PRESCALE_REG = '{8'h18, 8'h1A, 8'h1C};
   localparam addr3_type CONTROL_REG  = '{8'h30, 8'h38, 8'h48};
   localparam addr3_type PRESET_LO    = '{8'h32, 8'h3A, 8'h4A};
   localparam addr3_type COUNTER_LO   = '{8'h36, 8'h3E, 8'h4E};

   // Item as classified by the front end.
   typedef struct packed {
      logic       is_write;
      logic       is_read;
      logic       is_sec;
      logic       is_fast;
      logic       is_cycle;
      logic [7:0] address;
      logic [7:0] write_data;
      logic [7:0] keys;
   } item_type;

   function automatic logic [11:0] period_last(input logic [2:0] sel);
      logic [11:0] p;
      case (sel)
         3'd0: p = 12'd1;
         3'd1: p = 12'd7;
         3'd2: p = 12'd31;
         3'd3: p = 12'd63;
         3'd4: p = 12'd127;
         3'd5: p = 12'd255;
         3'd6: p = 12'd1023;
         default: p = 12'd4095;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/htrb_front.sv =====
// Front end: accepts request beats and classifies them into decoded items.
// Depends on htrb_pkg.
`default_nettype none
module htrb_front import htrb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_command,
   input  wire logic [7:0] req_address,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_keys,
   output logic            item_valid,
   output item_type        item,
   input  wire logic       item_ready
);
   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_ready = !valid_ff || item_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in.is_write   = req_command == CMD_WRITE;
         item_in.is_read    = req_command == CMD_READ;
         item_in.is_sec     = req_command == CMD_SEC;
         item_in.is_fast    = req_command == CMD_FAST;
         item_in.is_cycle   = req_command == CMD_CYCLE;
         item_in.address    = req_address;
         item_in.write_data = req_write_data;
         item_in.keys       = req_keys;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule
`default_nettype wire

// ===== hdl/htrb_back.sv =====
// Back end: register file memory, timer registers, seconds and fast counters and
// three down-counters. Depends on htrb_pkg.
`default_nettype none
module htrb_back import htrb_pkg::*; #(
   parameter int REGISTER_COUNT = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire item_type   item,
   output logic            item_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data
);
   logic [7:0]  mem [REGISTER_COUNT];
   logic [7:0]  mem_rd_ff;
   logic        mem_we;
   logic [7:0]  mem_wa;
   logic [7:0]  mem_wd;
   logic        clr_busy_ff, clr_busy_in;
   logic [7:0]  clr_addr_ff, clr_addr_in;
   logic [23:0] sec_ff, sec_in;
   logic        sec_run_ff, sec_run_in;
   logic [7:0]  fast_ff, fast_in;
   logic        fast_run_ff, fast_run_in;
   logic        group_ff, group_in;
   logic [15:0] cnt_ff [3];
   logic [15:0] cnt_in [3];
   logic [11:0] pre_ff [3];
   logic [11:0] pre_in [3];
   logic [7:0]  prs_ff [3];
   logic [7:0]  prs_in [3];
   logic [7:0]  ctl_ff [3];
   logic [7:0]  ctl_in [3];
   logic [7:0]  plo_ff [3];
   logic [7:0]  plo_in [3];
   logic [7:0]  phi_ff [3];
   logic [7:0]  phi_in [3];
   logic [7:0]  clo_ff [3];
   logic [7:0]  clo_in [3];
   logic [7:0]  chi_ff [3];
   logic [7:0]  chi_in [3];
   logic        out_valid_ff, out_valid_in;
   logic        out_mem_ff, out_mem_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic        go;

   // Nothing is taken while the register file is being cleared after reset.
   assign item_ready = !clr_busy_ff && (!out_valid_ff || rsp_ready);
   assign go = item_valid && item_ready;

   always_comb begin
      logic [7:0]  d;
      logic [7:0]  a;
      logic [15:0] c;
      sec_in       = sec_ff;
      sec_run_in   = sec_run_ff;
      fast_in      = fast_ff;
      fast_run_in  = fast_run_ff;
      group_in     = group_ff;
      cnt_in       = cnt_ff;
      pre_in       = pre_ff;
      prs_in       = prs_ff;
      ctl_in       = ctl_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_addr_ff;
      mem_wd       = 8'h00;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_mem_in   = out_mem_ff;
      out_data_in  = out_data_ff;
      a = item.address;
      d = item.write_data;
      c = '0;
      if (clr_busy_ff) begin
         mem_we      = 1'b1;
         clr_addr_in = clr_addr_ff + 8'd1;
         if (clr_addr_ff == 8'hFF) clr_busy_in = 1'b0;
      end
      if (go) begin
         out_valid_in = 1'b1;
         out_mem_in   = 1'b0;
         out_data_in  = 8'h00;
         if (item.is_read) begin
            case (a)
               ADDR_SEC_B0:   out_data_in = sec_ff[7:0];
               ADDR_SEC_B1:   out_data_in = sec_ff[15:8];
               ADDR_SEC_B2:   out_data_in = sec_ff[23:16];
               ADDR_FAST_CNT: out_data_in = fast_ff;
               ADDR_KEYS:     out_data_in = item.keys;
               default:       out_mem_in  = 1'b1;
            endcase
            // Counter registers are also written by the timers, so they live in flops.
            for (int t = 0; t < 3; t++) begin
               if (a == COUNTER_LO[t]) begin
                  out_mem_in  = 1'b0;
                  out_data_in = clo_ff[t];
               end
               if (a == COUNTER_LO[t] + 8'd1) begin
                  out_mem_in  = 1'b0;
                  out_data_in = chi_ff[t];
               end
            end
         end
         if (item.is_sec && sec_run_ff) sec_in = sec_ff + 24'd1;
         if (item.is_fast && fast_run_ff) fast_in = fast_ff + 8'd1;
         if (item.is_write && !(a inside {ADDR_SEC_B0, ADDR_SEC_B1, ADDR_SEC_B2,
                                          ADDR_FAST_CNT, ADDR_KEYS})) begin
            case (a)
               ADDR_SEC_CTL: begin
                  sec_run_in = d[0];
                  if (d[1]) sec_in = '0;
                  d[1] = 1'b0;
               end
               ADDR_FAST_CTL: begin
                  fast_run_in = d[0];
                  if (d[1]) fast_in = '0;
                  d[1] = 1'b0;
               end
               ADDR_GROUP: group_in = d[5];
               8'h82: d = d & 8'hF8;
               8'h84, 8'h89: d = d & 8'h1F;
               8'h87: d = d & 8'hC0;
               default: ;
            endcase
            for (int t = 0; t < 3; t++) begin
               if (a == PRESCALE_REG[t]) begin
                  if (d[2:0] != prs_ff[t][2:0]) pre_in[t] = '0;
                  prs_in[t] = d;
               end
               if (a == CONTROL_REG[t]) begin
                  if (d[2]) begin
                     cnt_in[t] = {phi_ff[t], plo_ff[t]};
                     clo_in[t] = plo_ff[t];
                     chi_in[t] = phi_ff[t];
                  end
                  d[2] = 1'b0;
                  ctl_in[t] = d;
               end
               if (a == PRESET_LO[t]) plo_in[t] = d;
               if (a == PRESET_LO[t] + 8'd1) phi_in[t] = d;
               if (a == COUNTER_LO[t]) clo_in[t] = d;
               if (a == COUNTER_LO[t] + 8'd1) chi_in[t] = d;
            end
            mem_we = 1'b1;
            mem_wa = a;
            mem_wd = d;
         end
         if (item.is_cycle && group_ff) begin
            for (int t = 0; t < 3; t++) begin
               if (prs_ff[t][3]) begin
                  if (pre_ff[t] >= period_last(prs_ff[t][2:0])) begin
                     pre_in[t] = '0;
                     c = cnt_ff[t] - 16'd1;
                     if (c == 16'hFFFF) c = {phi_ff[t], plo_ff[t]};
                     cnt_in[t] = c;
                     chi_in[t] = c[15:8];
                     if (ctl_ff[t][7]) clo_in[t] = c[7:0];
                  end else begin
                     pre_in[t] = pre_ff[t] + 12'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (go && item.is_read) mem_rd_ff <= mem[item.address];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1; clr_addr_ff <= '0;
         sec_ff <= '0; sec_run_ff <= 1'b0; fast_ff <= '0; fast_run_ff <= 1'b0;
         group_ff <= 1'b0; cnt_ff <= '{default: '0}; pre_ff <= '{default: '0};
         prs_ff <= '{default: '0}; ctl_ff <= '{default: '0};
         plo_ff <= '{default: '0}; phi_ff <= '{default: '0};
         clo_ff <= '{default: '0}; chi_ff <= '{default: '0};
         out_valid_ff <= 1'b0; out_mem_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in; clr_addr_ff <= clr_addr_in;
         sec_ff <= sec_in; sec_run_ff <= sec_run_in; fast_ff <= fast_in;
         fast_run_ff <= fast_run_in; group_ff <= group_in;
         cnt_ff <= cnt_in; pre_ff <= pre_in;
         prs_ff <= prs_in; ctl_ff <= ctl_in;
         plo_ff <= plo_in; phi_ff <= phi_in;
         clo_ff <= clo_in; chi_ff <= chi_in;
         out_valid_ff <= out_valid_in; out_mem_ff <= out_mem_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_mem_ff ? mem_rd_ff : out_data_ff;
endmodule
`default_nettype wire

// ===== hdl/handheld_timer_register_block.sv =====
// Timer and register file of a small handheld.
// A request beat passes the front register, then the output register, before it
// leaves as a response beat. Throughput: one item per cycle while responses are
// taken and no clear pass runs. Synchronous reset clears the counters and both
// pipeline stages; a pass over all 256 addresses after reset then zeroes the
// register file, and only one request beat is taken until that pass is over.
`default_nettype none
module handheld_timer_register_block import htrb_pkg::*; #(
   parameter int REGISTER_COUNT = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_command,
   input  wire logic [7:0] req_address,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_keys,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data
);
   logic     item_valid, item_ready;
   item_type item;

   htrb_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_address,
      .req_write_data, .req_keys, .item_valid, .item, .item_ready
   );

   htrb_back #(.REGISTER_COUNT(REGISTER_COUNT)) u_back (
      .clock, .reset, .item_valid, .item, .item_ready,
      .rsp_valid, .rsp_ready, .rsp_read_data
   );

   // A response that is not taken must hold its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("response changed while stalled");

   // Non-read items always answer with zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      item_valid && item_ready && !item.is_read |=> rsp_read_data == 8'h00)
      else $error("non-read item gave non-zero data");

   // The front end never drops an item when the back end stalls.
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_ready |=> item_valid)
      else $error("queued item lost");
endmodule
`default_nettype wire

// ===== bench/tb_handheld_timer_register_block.sv =====
// Self-checking bench for the handheld timer register block: drives bus writes, reads
// and tick events, predicts every response byte and compares it with the block's response.
// Depends on htrb_pkg and handheld_timer_register_block.
`default_nettype none
module tb_handheld_timer_register_block;
   timeunit 1ns;
   timeprecision 1ps;
   import htrb_pkg::*;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] address;
      logic [7:0] write_data;
      logic [7:0] keys;
   } bus_item_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_command = '0;
   logic [7:0] req_address = '0;
   logic [7:0] req_write_data = '0;
   logic [7:0] req_keys = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;

   handheld_timer_register_block i_dut (.*);

   always #1 clock = ~clock;

   bus_item_t  pending_items[$];
   logic [7:0] expected_bytes[$];
   int         send_idle_pct = 31;
   int         recv_idle_pct = 59;
   int         error_count = 0;
   longint     cycle_count = 0;

   // Shadow state of the block.
   logic [7:0]  regs[256];
   logic [23:0] sec_count;
   logic        sec_run;
   logic [7:0]  fast_count;
   logic        fast_run;
   logic        group_en;
   logic [15:0] down_cnt[3];
   logic [11:0] presc_cnt[3];

   function automatic logic [12:0] tick_period(input logic [2:0] sel);
      case (sel)
         3'd0: return 13'd2;
         3'd1: return 13'd8;
         3'd2: return 13'd32;
         3'd3: return 13'd64;
         3'd4: return 13'd128;
         3'd5: return 13'd256;
         3'd6: return 13'd1024;
         default: return 13'd4096;
      endcase
   endfunction

   function automatic logic [15:0] preset_value(input int t);
      return {regs[PRESET_LO[t] + 8'd1], regs[PRESET_LO[t]]};
   endfunction

   task automatic cycle_timers();
      logic [7:0]  ctl;
      logic [12:0] n;
      logic [15:0] c;
      for (int t = 0; t < 3; t++) begin
         ctl = regs[PRESCALE_REG[t]];
         if (!group_en || !ctl[3]) continue;
         n = {1'b0, presc_cnt[t]} + 13'd1;
         if (n >= tick_period(ctl[2:0])) begin
            presc_cnt[t] = '0;
            c = down_cnt[t] - 16'd1;
            if (c == 16'hFFFF) c = preset_value(t);
            down_cnt[t] = c;
            regs[COUNTER_LO[t] + 8'd1] = c[15:8];
            if (regs[CONTROL_REG[t]][7]) regs[COUNTER_LO[t]] = c[7:0];
         end else begin
            presc_cnt[t] = n[11:0];
         end
      end
   endtask

   task automatic apply_write(input logic [7:0] a, input logic [7:0] d);
      for (int t = 0; t < 3; t++) begin
         if (a == PRESCALE_REG[t] && d[2:0] != regs[a][2:0]) presc_cnt[t] = '0;
         if (a == CONTROL_REG[t]) begin
            if (d[2]) begin
               down_cnt[t] = preset_value(t);
               regs[COUNTER_LO[t]] = regs[PRESET_LO[t]];
               regs[COUNTER_LO[t] + 8'd1] = regs[PRESET_LO[t] + 8'd1];
            end
            d[2] = 1'b0;
         end
      end
      case (a)
         ADDR_SEC_CTL: begin
            sec_run = d[0];
            if (d[1]) sec_count = '0;
            d[1] = 1'b0;
         end
         ADDR_FAST_CTL: begin
            fast_run = d[0];
            if (d[1]) fast_count = '0;
            d[1] = 1'b0;
         end
         ADDR_SEC_B0, ADDR_SEC_B1, ADDR_SEC_B2, ADDR_FAST_CNT, ADDR_KEYS: return;
         ADDR_GROUP: group_en = d[5];
         8'h82: d = d & 8'hF8;
         8'h84, 8'h89: d = d & 8'h1F;
         8'h87: d = d & 8'hC0;
         default: ;
      endcase
      regs[a] = d;
   endtask

   function automatic logic [7:0] read_value(input logic [7:0] a, input logic [7:0] k);
      case (a)
         ADDR_SEC_B0: return sec_count[7:0];
         ADDR_SEC_B1: return sec_count[15:8];
         ADDR_SEC_B2: return sec_count[23:16];
         ADDR_FAST_CNT: return fast_count;
         ADDR_KEYS: return k;
         default: return regs[a];
      endcase
   endfunction

   task automatic predict_beat(input bus_item_t it);
      logic [7:0] r;
      r = '0;
      case (it.command)
         CMD_WRITE: apply_write(it.address, it.write_data);
         CMD_READ:  r = read_value(it.address, it.keys);
         CMD_SEC:   if (sec_run) sec_count = sec_count + 24'd1;
         CMD_FAST:  if (fast_run) fast_count = fast_count + 8'd1;
         CMD_CYCLE: cycle_timers();
         default: ;
      endcase
      expected_bytes.push_back(r);
   endtask

   // Driver: a new beat is presented only after the previous one was taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_beat({req_command, req_address, req_write_data, req_keys});
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               bus_item_t it;
               it = pending_items.pop_front();
               req_valid      <= 1'b1;
               req_command    <= it.command;
               req_address    <= it.address;
               req_write_data <= it.write_data;
               req_keys       <= it.keys;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("read_data: unexpected beat, actual %02h", rsp_read_data);
            error_count++;
         end else begin
            logic [7:0] e;
            e = expected_bytes.pop_front();
            if (rsp_read_data !== e) begin
               $error("read_data: expected %02h, actual %02h", e, rsp_read_data);
               error_count++;
            end
         end
      end
   end

   function automatic bus_item_t make_item(input int c, input int a, input int d);
      bus_item_t it;
      it.command = c[2:0];
      it.address = a[7:0];
      it.write_data = d[7:0];
      it.keys = 8'($urandom);
      return it;
   endfunction

   // Addresses that matter for the timers and special registers.
   localparam logic [7:0] HOT_ADDRS [24] = '{
      8'h08, 8'h09, 8'h0A, 8'h0B, 8'h18, 8'h19, 8'h1A, 8'h1C, 8'h30, 8'h32, 8'h33,
      8'h36, 8'h37, 8'h38, 8'h3A, 8'h3B, 8'h48, 8'h4A, 8'h4B, 8'h4E, 8'h40, 8'h41,
      8'h52, 8'h87};

   task automatic queue_random(input int count);
      int r, c, a;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 40) c = CMD_CYCLE;
         else if (r < 60) c = CMD_WRITE;
         else if (r < 85) c = CMD_READ;
         else if (r < 92) c = $urandom_range(1) ? CMD_SEC : CMD_FAST;
         else c = $urandom_range(7);
         a = $urandom_range(2) != 0 ? HOT_ADDRS[$urandom_range(23)] : $urandom_range(255);
         // Mostly small periods with the timers enabled, so the counters move.
         if (c == CMD_WRITE && (a == 8'h18 || a == 8'h1A || a == 8'h1C) &&
             $urandom_range(3) != 0)
            pending_items.push_back(make_item(c, a, 8'h08 | $urandom_range(2)));
         else if (c == CMD_WRITE && a == ADDR_GROUP && $urandom_range(3) != 0)
            pending_items.push_back(make_item(c, a, $urandom | 8'h20));
         else
            pending_items.push_back(make_item(c, a, $urandom));
      end
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_bytes.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 256; i++) regs[i] = '0;
      sec_count = '0; sec_run = 0; fast_count = '0; fast_run = 0; group_en = 0;
      for (int t = 0; t < 3; t++) begin
         down_cnt[t] = '0;
         presc_cnt[t] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: special registers, masks, presets, unused commands.
      pending_items.push_back(make_item(CMD_WRITE, 8'h08, 8'hFF));
      pending_items.push_back(make_item(CMD_SEC, 0, 0));
      pending_items.push_back(make_item(CMD_READ, 8'h09, 0));
      pending_items.push_back(make_item(CMD_READ, 8'h08, 0));
      pending_items.push_back(make_item(CMD_WRITE, 8'h40, 8'h03));
      pending_items.push_back(make_item(CMD_FAST, 0, 0));
      pending_items.push_back(make_item(CMD_READ, 8'h41, 0));
      pending_items.push_back(make_item(CMD_WRITE, 8'h0A, 8'h55));
      pending_items.push_back(make_item(CMD_READ, 8'h52, 0));
      pending_items.push_back(make_item(CMD_WRITE, 8'h82, 8'hFF));
      pending_items.push_back(make_item(CMD_WRITE, 8'h84, 8'hFF));
      pending_items.push_back(make_item(CMD_WRITE, 8'h87, 8'hFF));
      pending_items.push_back(make_item(CMD_READ, 8'h87, 0));
      pending_items.push_back(make_item(CMD_WRITE, 8'h32, 8'h02));
      pending_items.push_back(make_item(CMD_WRITE, 8'h30, 8'hFF));
      pending_items.push_back(make_item(CMD_WRITE, 8'h19, 8'h20));
      pending_items.push_back(make_item(CMD_WRITE, 8'h18, 8'h08));
      for (int i = 0; i < 6; i++) pending_items.push_back(make_item(CMD_CYCLE, 0, 0));
      pending_items.push_back(make_item(CMD_READ, 8'h36, 0));
      pending_items.push_back(make_item(7, 8'hFF, 8'hFF));
      queue_random(580);
      drain();
      send_idle_pct = 59; recv_idle_pct = 31;
      queue_random(580);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(580);
      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count > 200000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
`default_nettype wire
